### src/assert_macros.svh
// Assertion macros shared by the vertex de-duplication RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define VAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define VAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/vad_pkg.sv
// Shared constants and controller/datapath interface types for vertex de-duplication.
package vad_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned IDX_W       = 8;

  typedef struct packed {
    logic start;   // capture the vertex and clear the search
    logic scan;    // step the table scan
    logic commit;  // append misses and load the result
  } vad_cmd_t;

  typedef struct packed {
    logic scan_done;
  } vad_sts_t;

endpackage

### src/vertex_attribute_dedup.sv
// A vertex is accepted, then its scan covers N entries, where N is the largest fill count among
// the searched tables, at most TABLE_DEPTH (256), then the result is committed and presented.
// One vertex at a time: the scan reads one entry per cycle through each table's single read port.
// Reset: asynchronous, active low; empties all tables (fill counts to zero) and goes idle.
module vertex_attribute_dedup (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [vad_pkg::WORD_W-1:0] pos_x_i,
  input  logic [vad_pkg::WORD_W-1:0] pos_y_i,
  input  logic [vad_pkg::WORD_W-1:0] pos_z_i,
  input  logic [vad_pkg::WORD_W-1:0] tex_u_i,
  input  logic [vad_pkg::WORD_W-1:0] tex_v_i,
  input  logic [vad_pkg::WORD_W-1:0] norm_x_i,
  input  logic [vad_pkg::WORD_W-1:0] norm_y_i,
  input  logic [vad_pkg::WORD_W-1:0] norm_z_i,
  input  logic                       use_normal_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [vad_pkg::IDX_W-1:0]  pos_index_o,
  output logic [vad_pkg::IDX_W-1:0]  tex_index_o,
  output logic [vad_pkg::IDX_W-1:0]  norm_index_o,
  output logic                       norm_valid_o,
  output logic                       pos_added_o,
  output logic                       tex_added_o,
  output logic                       norm_added_o,
  output logic                       overflow_o
);

  vad_pkg::vad_cmd_t cmd;
  vad_pkg::vad_sts_t sts;

  vad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vad_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .tex_u_i      (tex_u_i),
    .tex_v_i      (tex_v_i),
    .norm_x_i     (norm_x_i),
    .norm_y_i     (norm_y_i),
    .norm_z_i     (norm_z_i),
    .use_normal_i (use_normal_i),
    .pos_index_o  (pos_index_o),
    .tex_index_o  (tex_index_o),
    .norm_index_o (norm_index_o),
    .norm_valid_o (norm_valid_o),
    .pos_added_o  (pos_added_o),
    .tex_added_o  (tex_added_o),
    .norm_added_o (norm_added_o),
    .overflow_o   (overflow_o)
  );

endmodule

### src/vad_ctrl.sv
// Controller state machine: accept a vertex, run the scan, commit, present the result.
`include "assert_macros.svh"

module vad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  vad_pkg::vad_sts_t sts_i,
  output vad_pkg::vad_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `VAD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == ST_IDLE), "controller not idle in reset")
  `VAD_ASSERT(a_ready_xor_valid, !(in_ready_o && out_valid_o), "input and output open together")
  `VAD_ASSERT(a_commit_to_out, cmd_o.commit |=> out_valid_o, "commit did not present a result")

endmodule

### src/vad_datapath.sv
// Datapath: attribute tables, one-entry-per-cycle scan, append logic and result registers.
`include "assert_macros.svh"

module vad_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vad_pkg::vad_cmd_t                 cmd_i,
  output vad_pkg::vad_sts_t                 sts_o,
  input  logic [vad_pkg::WORD_W-1:0]        pos_x_i,
  input  logic [vad_pkg::WORD_W-1:0]        pos_y_i,
  input  logic [vad_pkg::WORD_W-1:0]        pos_z_i,
  input  logic [vad_pkg::WORD_W-1:0]        tex_u_i,
  input  logic [vad_pkg::WORD_W-1:0]        tex_v_i,
  input  logic [vad_pkg::WORD_W-1:0]        norm_x_i,
  input  logic [vad_pkg::WORD_W-1:0]        norm_y_i,
  input  logic [vad_pkg::WORD_W-1:0]        norm_z_i,
  input  logic                              use_normal_i,
  output logic [vad_pkg::IDX_W-1:0]         pos_index_o,
  output logic [vad_pkg::IDX_W-1:0]         tex_index_o,
  output logic [vad_pkg::IDX_W-1:0]         norm_index_o,
  output logic                              norm_valid_o,
  output logic                              pos_added_o,
  output logic                              tex_added_o,
  output logic                              norm_added_o,
  output logic                              overflow_o
);

  localparam int unsigned W3 = 3 * vad_pkg::WORD_W;
  localparam int unsigned W2 = 2 * vad_pkg::WORD_W;
  localparam logic [vad_pkg::CNT_W-1:0] FULL = vad_pkg::CNT_W'(vad_pkg::TABLE_DEPTH);

  logic [W3-1:0] pos_mem  [vad_pkg::TABLE_DEPTH];
  logic [W2-1:0] tex_mem  [vad_pkg::TABLE_DEPTH];
  logic [W3-1:0] norm_mem [vad_pkg::TABLE_DEPTH];

  logic [W3-1:0] pos_key_q, norm_key_q;
  logic [W2-1:0] tex_key_q;
  logic          use_n_q;

  logic [W3-1:0] pos_rd_q, norm_rd_q;
  logic [W2-1:0] tex_rd_q;

  logic [vad_pkg::CNT_W-1:0]  pos_cnt_q, tex_cnt_q, norm_cnt_q;
  logic [vad_pkg::CNT_W-1:0]  iss_cnt_q, limit_q, limit_d;
  logic                       cmp_vld_q;
  logic [vad_pkg::ADDR_W-1:0] cmp_addr_q;
  logic                       iss_en;

  logic                       pos_found_q, tex_found_q, norm_found_q;
  logic [vad_pkg::ADDR_W-1:0] pos_fidx_q, tex_fidx_q, norm_fidx_q;
  logic                       pos_hit, tex_hit, norm_hit;

  logic pos_full, tex_full, norm_full;
  logic pos_add, tex_add, norm_add;
  logic pos_ovf, tex_ovf, norm_ovf;
  logic [vad_pkg::ADDR_W-1:0] pos_res, tex_res, norm_res;

  // Scan runs up to the largest fill count among the tables being searched.
  always_comb begin
    limit_d = (pos_cnt_q > tex_cnt_q) ? pos_cnt_q : tex_cnt_q;
    if (use_normal_i && (norm_cnt_q > limit_d)) begin
      limit_d = norm_cnt_q;
    end
  end

  assign iss_en          = cmd_i.scan && (iss_cnt_q < limit_q);
  assign sts_o.scan_done = (iss_cnt_q >= limit_q) && !cmp_vld_q;

  // Compare only entries below each table's own fill count.
  assign pos_hit  = cmp_vld_q && !pos_found_q
                 && (vad_pkg::CNT_W'(cmp_addr_q) < pos_cnt_q) && (pos_rd_q == pos_key_q);
  assign tex_hit  = cmp_vld_q && !tex_found_q
                 && (vad_pkg::CNT_W'(cmp_addr_q) < tex_cnt_q) && (tex_rd_q == tex_key_q);
  assign norm_hit = cmp_vld_q && !norm_found_q
                 && (vad_pkg::CNT_W'(cmp_addr_q) < norm_cnt_q) && (norm_rd_q == norm_key_q);

  assign pos_full  = (pos_cnt_q == FULL);
  assign tex_full  = (tex_cnt_q == FULL);
  assign norm_full = (norm_cnt_q == FULL);

  assign pos_add  = !pos_found_q && !pos_full;
  assign tex_add  = !tex_found_q && !tex_full;
  assign norm_add = use_n_q && !norm_found_q && !norm_full;

  assign pos_ovf  = !pos_found_q && pos_full;
  assign tex_ovf  = !tex_found_q && tex_full;
  assign norm_ovf = use_n_q && !norm_found_q && norm_full;

  always_comb begin
    pos_res  = '0;
    tex_res  = '0;
    norm_res = '0;
    if (pos_found_q) begin
      pos_res = pos_fidx_q;
    end else if (pos_add) begin
      pos_res = pos_cnt_q[vad_pkg::ADDR_W-1:0];
    end
    if (tex_found_q) begin
      tex_res = tex_fidx_q;
    end else if (tex_add) begin
      tex_res = tex_cnt_q[vad_pkg::ADDR_W-1:0];
    end
    if (use_n_q && norm_found_q) begin
      norm_res = norm_fidx_q;
    end else if (norm_add) begin
      norm_res = norm_cnt_q[vad_pkg::ADDR_W-1:0];
    end
  end

  // Table storage: one write port for appends, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && pos_add) begin
      pos_mem[pos_cnt_q[vad_pkg::ADDR_W-1:0]] <= pos_key_q;
    end
    if (iss_en) begin
      pos_rd_q <= pos_mem[iss_cnt_q[vad_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && tex_add) begin
      tex_mem[tex_cnt_q[vad_pkg::ADDR_W-1:0]] <= tex_key_q;
    end
    if (iss_en) begin
      tex_rd_q <= tex_mem[iss_cnt_q[vad_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && norm_add) begin
      norm_mem[norm_cnt_q[vad_pkg::ADDR_W-1:0]] <= norm_key_q;
    end
    if (iss_en) begin
      norm_rd_q <= norm_mem[iss_cnt_q[vad_pkg::ADDR_W-1:0]];
    end
  end

  // Vertex capture and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pos_key_q  <= {pos_x_i, pos_y_i, pos_z_i};
      tex_key_q  <= {tex_u_i, tex_v_i};
      norm_key_q <= {norm_x_i, norm_y_i, norm_z_i};
      use_n_q    <= use_normal_i;
      limit_q    <= limit_d;
    end
    if (cmp_vld_q || iss_en) begin
      cmp_addr_q <= iss_cnt_q[vad_pkg::ADDR_W-1:0];
    end
    if (pos_hit) begin
      pos_fidx_q <= cmp_addr_q;
    end
    if (tex_hit) begin
      tex_fidx_q <= cmp_addr_q;
    end
    if (norm_hit) begin
      norm_fidx_q <= cmp_addr_q;
    end
    if (cmd_i.commit) begin
      pos_index_o  <= vad_pkg::IDX_W'(pos_res);
      tex_index_o  <= vad_pkg::IDX_W'(tex_res);
      norm_index_o <= vad_pkg::IDX_W'(norm_res);
      norm_valid_o <= use_n_q;
      pos_added_o  <= pos_add;
      tex_added_o  <= tex_add;
      norm_added_o <= norm_add;
      overflow_o   <= pos_ovf || tex_ovf || norm_ovf;
    end
  end

  // Scan control and fill counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_cnt_q    <= '0;
      cmp_vld_q    <= 1'b0;
      pos_found_q  <= 1'b0;
      tex_found_q  <= 1'b0;
      norm_found_q <= 1'b0;
      pos_cnt_q    <= '0;
      tex_cnt_q    <= '0;
      norm_cnt_q   <= '0;
    end else begin
      cmp_vld_q <= iss_en;
      if (cmd_i.start) begin
        iss_cnt_q    <= '0;
        pos_found_q  <= 1'b0;
        tex_found_q  <= 1'b0;
        norm_found_q <= 1'b0;
      end else begin
        if (iss_en) begin
          iss_cnt_q <= iss_cnt_q + 1'b1;
        end
        if (pos_hit) begin
          pos_found_q <= 1'b1;
        end
        if (tex_hit) begin
          tex_found_q <= 1'b1;
        end
        if (norm_hit) begin
          norm_found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        if (pos_add) begin
          pos_cnt_q <= pos_cnt_q + 1'b1;
        end
        if (tex_add) begin
          tex_cnt_q <= tex_cnt_q + 1'b1;
        end
        if (norm_add) begin
          norm_cnt_q <= norm_cnt_q + 1'b1;
        end
      end
    end
  end

  `VAD_ASSERT(a_cnt_bound, (pos_cnt_q <= FULL) && (tex_cnt_q <= FULL) && (norm_cnt_q <= FULL), "fill count beyond table depth")
  `VAD_ASSERT(a_cnt_commit, !cmd_i.commit |=> ($stable(pos_cnt_q) && $stable(tex_cnt_q) && $stable(norm_cnt_q)), "fill count moved outside commit")
  `VAD_ASSERT(a_hit_no_add, cmd_i.commit |=> !(pos_added_o && pos_found_q), "position both found and appended")

endmodule
